@@ hdl/kda_pkg.sv @@
package kda_pkg;

    localparam int NUM_KEYS       = 12;
    localparam int LEVEL_BITS     = 12;
    localparam int STICK_BITS     = 12;
    localparam int POS_BITS       = 2;
    localparam int NUM_SWITCHES   = 6;
    localparam int SW_BITS        = NUM_SWITCHES * POS_BITS;
    localparam int COUNT_BITS     = 8;
    localparam int OP_BITS        = 3;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 12;
    localparam int STICK_SEL_BITS = 2;

    localparam logic [LEVEL_BITS-1:0] LVL_LOW  = LEVEL_BITS'(1) << (LEVEL_BITS - 2);
    localparam logic [LEVEL_BITS-1:0] LVL_HIGH = LEVEL_BITS'(3) << (LEVEL_BITS - 2);

    localparam logic [NUM_KEYS-1:0] KEY_ENTER = NUM_KEYS'(1);
    localparam logic [NUM_KEYS-1:0] KEY_EXIT  = NUM_KEYS'(2);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic [POS_BITS-1:0] POS_UP   = POS_BITS'(0);
    localparam logic [POS_BITS-1:0] POS_MID  = POS_BITS'(1);
    localparam logic [POS_BITS-1:0] POS_DOWN = POS_BITS'(2);

    localparam logic [7:0] RESET_REPEAT_DELAY  = 8'd25;
    localparam logic [7:0] RESET_REPEAT_PERIOD = 8'd5;

    typedef enum logic [OP_BITS-1:0] {
        OP_SCAN        = 3'd0,
        OP_TEST_CLEAR  = 3'd1,
        OP_CLEAR       = 3'd2,
        OP_FLUSH       = 3'd3,
        OP_STOP_REPEAT = 3'd4
    } op_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_REPEAT_DELAY     = 3'd0,
        REG_REPEAT_PERIOD    = 3'd1,
        REG_VIRT_E_STICK     = 3'd2,
        REG_VIRT_E_THRESHOLD = 3'd3,
        REG_VIRT_F_STICK     = 3'd4,
        REG_VIRT_F_THRESHOLD = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [OP_BITS-1:0]           operation;
        logic [NUM_KEYS-1:0]          key_lines;
        logic [LEVEL_BITS-1:0]        sw_a_level;
        logic [LEVEL_BITS-1:0]        sw_b_level;
        logic [LEVEL_BITS-1:0]        sw_c_level;
        logic [LEVEL_BITS-1:0]        sw_d_level;
        logic signed [STICK_BITS-1:0] stick_0;
        logic signed [STICK_BITS-1:0] stick_1;
        logic signed [STICK_BITS-1:0] stick_2;
        logic signed [STICK_BITS-1:0] stick_3;
        logic                         hand_pin;
        logic [NUM_KEYS-1:0]          key_select;
    } kda_item_t;

    typedef struct packed {
        logic [NUM_KEYS-1:0] down_flags;
        logic [NUM_KEYS-1:0] hold_flags;
        logic [SW_BITS-1:0]  switch_state;
        logic                hand_mode;
        logic                test_hit;
        logic                press_event;
        logic                activity;
    } kda_result_t;

    typedef struct packed {
        logic [7:0]                   repeat_delay;
        logic [7:0]                   repeat_period;
        logic [STICK_SEL_BITS-1:0]    virt_e_stick;
        logic signed [STICK_BITS-1:0] virt_e_threshold;
        logic [STICK_SEL_BITS-1:0]    virt_f_stick;
        logic signed [STICK_BITS-1:0] virt_f_threshold;
    } kda_cfg_t;

    typedef struct packed {
        logic [NUM_KEYS-1:0] key;
        logic [SW_BITS-1:0]  switches;
    } kda_scan_t;

    function automatic logic [POS_BITS-1:0] classify_level(input logic [LEVEL_BITS-1:0] lvl);
        logic [POS_BITS-1:0] pos;
        if (lvl <= LVL_LOW)
        begin
            pos = POS_UP;
        end
        else if (lvl >= LVL_HIGH)
        begin
            pos = POS_DOWN;
        end
        else
        begin
            pos = POS_MID;
        end
        return pos;
    endfunction

endpackage

@@ hdl/kda_if.sv @@
interface kda_in_if import kda_pkg::*;;
    logic      valid;
    logic      ready;
    kda_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface kda_out_if import kda_pkg::*;;
    logic        valid;
    logic        ready;
    kda_result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
    modport monitor (input valid, input payload, input ready);
endinterface

@@ hdl/kda_decode.sv @@
module kda_decode import kda_pkg::*;
(
    input  kda_item_t item,
    input  kda_cfg_t  cfg,
    output kda_scan_t scan
);

    logic [NUM_KEYS-1:0]          pressed;
    logic signed [STICK_BITS-1:0] stick_e;
    logic signed [STICK_BITS-1:0] stick_f;
    logic [POS_BITS-1:0]          pos_e;
    logic [POS_BITS-1:0]          pos_f;

    // The lowest pressed line wins, so isolating the lowest set bit gives the one-hot code.
    assign pressed  = ~item.key_lines;
    assign scan.key = pressed & (~pressed + NUM_KEYS'(1));

    always_comb
    begin
        case (cfg.virt_e_stick)
            2'd0:    stick_e = item.stick_0;
            2'd1:    stick_e = item.stick_1;
            2'd2:    stick_e = item.stick_2;
            default: stick_e = item.stick_3;
        endcase
        case (cfg.virt_f_stick)
            2'd0:    stick_f = item.stick_0;
            2'd1:    stick_f = item.stick_1;
            2'd2:    stick_f = item.stick_2;
            default: stick_f = item.stick_3;
        endcase
    end

    assign pos_e = (stick_e <= cfg.virt_e_threshold) ? POS_DOWN : POS_UP;
    assign pos_f = (stick_f <= cfg.virt_f_threshold) ? POS_DOWN : POS_UP;

    assign scan.switches = {pos_f, pos_e,
                            classify_level(item.sw_d_level),
                            classify_level(item.sw_c_level),
                            classify_level(item.sw_b_level),
                            classify_level(item.sw_a_level)};

endmodule

@@ hdl/kda_state.sv @@
module kda_state import kda_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step_en,
    input  kda_item_t   item,
    input  kda_scan_t   scan,
    input  kda_cfg_t    cfg,
    output kda_result_t result
);

    logic [NUM_KEYS-1:0]   last_key_reg, last_key_next;
    logic [COUNT_BITS-1:0] press_count_reg, press_count_next;
    logic [NUM_KEYS-1:0]   down_reg, down_next;
    logic [NUM_KEYS-1:0]   hold_reg, hold_next;
    logic [SW_BITS-1:0]    last_switches_reg, last_switches_next;
    logic [SW_BITS-1:0]    confirmed_reg, confirmed_next;
    logic                  hand_reg, hand_next;
    logic [COUNT_BITS-1:0] count_mid;
    logic                  hit;
    logic                  press;
    logic                  act;

    always_comb
    begin
        last_key_next      = last_key_reg;
        press_count_next   = press_count_reg;
        down_next          = down_reg;
        hold_next          = hold_reg;
        last_switches_next = last_switches_reg;
        confirmed_next     = confirmed_reg;
        hand_next          = hand_reg;
        count_mid          = press_count_reg;
        hit                = 1'b0;
        press              = 1'b0;
        act                = 1'b0;

        case (item.operation)
            OP_SCAN:
            begin
                if (scan.key == last_key_reg)
                begin
                    if (scan.key != '0)
                    begin
                        if (press_count_reg == '0)
                        begin
                            down_next = down_reg & ~scan.key;
                            press     = 1'b1;
                            act       = 1'b1;
                        end
                        else if (press_count_reg >= cfg.repeat_delay)
                        begin
                            // Enter and exit report the hold but do not repeat.
                            hold_next = hold_reg & ~scan.key;
                            if (scan.key != KEY_ENTER && scan.key != KEY_EXIT)
                            begin
                                down_next = down_reg & ~scan.key;
                            end
                            count_mid = cfg.repeat_delay - cfg.repeat_period;
                            act       = 1'b1;
                        end
                        if (count_mid != COUNT_MAX)
                        begin
                            press_count_next = count_mid + COUNT_BITS'(1);
                        end
                        else
                        begin
                            press_count_next = count_mid;
                        end
                    end
                    else
                    begin
                        press_count_next = '0;
                        hold_next        = '1;
                    end
                end
                else
                begin
                    last_key_next = scan.key;
                end
                if (scan.switches == last_switches_reg)
                begin
                    confirmed_next = scan.switches;
                end
                else
                begin
                    last_switches_next = scan.switches;
                end
                hand_next = item.hand_pin;
            end
            OP_TEST_CLEAR:
            begin
                if ((down_reg & item.key_select) == '0)
                begin
                    down_next = down_reg | item.key_select;
                    hit       = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                down_next = down_reg | item.key_select;
            end
            OP_FLUSH:
            begin
                down_next        = '1;
                hold_next        = '1;
                press_count_next = '0;
            end
            OP_STOP_REPEAT:
            begin
                press_count_next = COUNT_BITS'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_key_reg      <= '0;
            press_count_reg   <= '0;
            down_reg          <= '1;
            hold_reg          <= '1;
            last_switches_reg <= '0;
            confirmed_reg     <= '1;
            hand_reg          <= 1'b0;
        end
        else if (step_en)
        begin
            last_key_reg      <= last_key_next;
            press_count_reg   <= press_count_next;
            down_reg          <= down_next;
            hold_reg          <= hold_next;
            last_switches_reg <= last_switches_next;
            confirmed_reg     <= confirmed_next;
            hand_reg          <= hand_next;
        end
    end

    assign result.down_flags   = down_next;
    assign result.hold_flags   = hold_next;
    assign result.switch_state = confirmed_next;
    assign result.hand_mode    = hand_next;
    assign result.test_hit     = hit;
    assign result.press_event  = press;
    assign result.activity     = act;

endmodule

@@ hdl/key_debounce_autorepeat.sv @@
// Keypad debounce with auto-repeat and switch position confirmation. Each item is
// either a scan tick carrying the raw key lines, switch levels and stick positions, or
// a host command (test-and-clear, clear, flush, stop repeat), and each item yields
// exactly one result with the flags after that item. An item goes into an input
// register, is decoded there and applied to the key and switch state, and the result
// is captured in the output register, from which it is presented and can be taken;
// one item is taken every cycle while the output side keeps up. Input ready follows
// output ready in the same cycle when both registers are full.
// Configuration registers are written through cfg_we, cfg_index and cfg_data and
// should only be changed while no item is in flight.
module key_debounce_autorepeat import kda_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    kda_in_if.sink                    item_in,
    kda_out_if.source                 item_out
);

    kda_cfg_t    cfg_reg, cfg_next;
    logic        stage_valid_reg, stage_valid_next;
    kda_item_t   stage_item_reg, stage_item_next;
    logic        out_valid_reg, out_valid_next;
    kda_result_t out_result_reg, out_result_next;
    logic        advance;
    kda_scan_t   scan;
    kda_result_t result;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_REPEAT_DELAY:     cfg_next.repeat_delay     = cfg_data[7:0];
                REG_REPEAT_PERIOD:    cfg_next.repeat_period    = cfg_data[7:0];
                REG_VIRT_E_STICK:     cfg_next.virt_e_stick     = cfg_data[STICK_SEL_BITS-1:0];
                REG_VIRT_E_THRESHOLD: cfg_next.virt_e_threshold = cfg_data[STICK_BITS-1:0];
                REG_VIRT_F_STICK:     cfg_next.virt_f_stick     = cfg_data[STICK_SEL_BITS-1:0];
                REG_VIRT_F_THRESHOLD: cfg_next.virt_f_threshold = cfg_data[STICK_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign advance       = stage_valid_reg && (!out_valid_reg || item_out.ready);
    assign item_in.ready = !stage_valid_reg || advance;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        stage_item_next  = stage_item_reg;
        out_valid_next   = out_valid_reg;
        out_result_next  = out_result_reg;
        if (item_in.valid && item_in.ready)
        begin
            stage_valid_next = 1'b1;
            stage_item_next  = item_in.payload;
        end
        else if (advance)
        begin
            stage_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next  = 1'b1;
            out_result_next = result;
        end
        else if (item_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.repeat_delay     <= RESET_REPEAT_DELAY;
            cfg_reg.repeat_period    <= RESET_REPEAT_PERIOD;
            cfg_reg.virt_e_stick     <= '0;
            cfg_reg.virt_e_threshold <= '0;
            cfg_reg.virt_f_stick     <= '0;
            cfg_reg.virt_f_threshold <= '0;
            stage_valid_reg          <= 1'b0;
            out_valid_reg            <= 1'b0;
        end
        else
        begin
            cfg_reg         <= cfg_next;
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_item_reg <= stage_item_next;
        out_result_reg <= out_result_next;
    end

    kda_decode u_decode
    (
        .item (stage_item_reg),
        .cfg  (cfg_reg),
        .scan (scan)
    );

    kda_state u_state
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (stage_item_reg),
        .scan    (scan),
        .cfg     (cfg_reg),
        .result  (result)
    );

    assign item_out.valid   = out_valid_reg;
    assign item_out.payload = out_result_reg;

endmodule

@@ hdl/kda_checker.sv @@
module kda_checker import kda_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        valid,
    input logic        ready,
    input kda_result_t payload
);

    // A test-and-clear never coincides with a scan event.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && payload.test_hit |-> !payload.press_event && !payload.activity)
        else $error("test hit reported together with a scan event");

    assert property (@(posedge clk) disable iff (!rst_n)
        valid && payload.press_event |-> payload.activity)
        else $error("press event without activity");

    // A new press always leaves at least one down flag cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && payload.press_event |-> payload.down_flags != '1)
        else $error("press event with all down flags set");

    assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(payload))
        else $error("stalled result item changed");

endmodule

bind key_debounce_autorepeat kda_checker u_kda_checker
(
    .clk     (clk),
    .rst_n   (rst_n),
    .valid   (item_out.valid),
    .ready   (item_out.ready),
    .payload (item_out.payload)
);
